[sv/nsf_pkg.sv]
// Shared constants, codes and helper functions of the NMEA sentence framer.
package nsf_pkg;

    localparam int CMD_MAX = 7;
    localparam int ARG_MAX = 80;
    localparam int POS_W   = $clog2(ARG_MAX + 2);
    localparam int IDX_W   = $clog2(CMD_MAX);
    localparam int CHK_MAX = 3;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_K      = 8'h4B;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_OK      = 3'd1,
        EV_BADSUM  = 3'd2,
        EV_LONGCMD = 3'd3,
        EV_LONGARG = 3'd4,
        EV_LONGSUM = 3'd5,
        EV_NOLF    = 3'd6
    } t_event;

    typedef enum logic [2:0] {
        KIND_OTHER = 3'd0,
        KIND_GPRMC = 3'd1,
        KIND_GPGSA = 3'd2,
        KIND_GPGGA = 3'd3,
        KIND_PMTK  = 3'd4
    } t_kind;

    typedef logic [CMD_MAX-1:0][7:0] t_cmd_store;

    typedef struct packed {
        logic [7:0] computed_checksum;
        logic [6:0] argument_length;
        logic [2:0] command_length;
        t_kind      sentence_kind;
        t_event     event_res;
    } t_result;

    // hex digit value; anything else is the byte minus '0', mod 256
    function automatic logic [7:0] hex_value(input logic [7:0] b);
        logic [7:0] v;
        if (b >= CH_UA && b <= CH_UF) begin
            v = b - CH_UA + 8'd10;
        end else if (b >= CH_LA && b <= CH_LF_HEX) begin
            v = b - CH_LA + 8'd10;
        end else begin
            v = b - CH_ZERO;
        end
        return v;
    endfunction

    function automatic t_kind classify(input t_cmd_store k);
        t_kind r;
        r = KIND_OTHER;
        if (k[0] == CH_G && k[1] == CH_P) begin
            if (k[2] == CH_R && k[3] == CH_M && k[4] == CH_C) begin
                r = KIND_GPRMC;
            end else if (k[2] == CH_G && k[3] == CH_S && k[4] == CH_A) begin
                r = KIND_GPGSA;
            end else if (k[2] == CH_G && k[3] == CH_G && k[4] == CH_A) begin
                r = KIND_GPGGA;
            end
        end else if (k[0] == CH_P && k[1] == CH_M && k[2] == CH_T && k[3] == CH_K) begin
            r = KIND_PMTK;
        end
        return r;
    endfunction

endpackage

[sv/nmea_sentence_framer.sv]
// Top level of the NMEA sentence framer: byte-wise sentence parser with status output.
//
// Takes one received character per transfer on the slave stream and returns exactly
// one registered status word per character on the master stream. A character
// can be taken every clock cycle: all per-character work (phase decode, XOR sum,
// checksum digit shift, command store write, type match) is one shallow level of
// logic between the parser state registers and the output register. The slave side
// stays ready while the output register is empty or is being drained in the same
// cycle, so throughput is one transfer per cycle as long as the sink keeps up.
// '$' starts a sentence; characters up to ',' are the command (first CMD_MAX kept),
// up to '*' the arguments, then up to two hex digits until CR, and LF completes.
// On LF the status carries the sentence type, the command and argument lengths and
// the XOR sum. The command store is never cleared between sentences, so leftovers
// of a longer earlier command take part in type matching. Over-long fields, a bad
// checksum or a missing LF abort back to waiting for '$'.
module nmea_sentence_framer
    import nsf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [2:0] event_res, [5:3] sentence_kind,
                                        // [8:6] command_length,
                                        // [15:9] argument_length,
                                        // [23:16] computed_checksum
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CMD,
        PH_ARG,
        PH_CHK,
        PH_CR
    } t_phase;

    t_phase           r_phase,   n_phase;
    logic [POS_W-1:0] r_pos,     n_pos;
    logic [7:0]       r_xor,     n_xor;
    logic [7:0]       r_rx_sum,  n_rx_sum;
    t_cmd_store       r_cmd,     n_cmd;
    logic [2:0]       r_cmd_len, n_cmd_len;
    logic [6:0]       r_arg_len, n_arg_len;
    logic             r_out_valid;
    t_result          r_out,     n_out;

    logic             w_take;
    logic [POS_W-1:0] w_pos_inc;
    logic [7:0]       b;

    // output register frees up when empty or drained this cycle
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_take        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    assign b         = s_axis_tdata;
    assign w_pos_inc = r_pos + 1'b1;

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_xor     = r_xor;
        n_rx_sum  = r_rx_sum;
        n_cmd     = r_cmd;
        n_cmd_len = r_cmd_len;
        n_arg_len = r_arg_len;
        n_out     = '0;
        n_out.event_res     = EV_NONE;
        n_out.sentence_kind = KIND_OTHER;

        case (r_phase)
            PH_CMD: begin
                n_xor = r_xor ^ b;
                if (b == CH_COMMA) begin
                    n_cmd_len = r_pos[2:0];
                    n_pos     = '0;
                    n_phase   = PH_ARG;
                end else begin
                    if (r_pos < POS_W'(CMD_MAX)) begin
                        n_cmd[r_pos[IDX_W-1:0]] = b;
                    end
                    n_pos = w_pos_inc;
                    if (w_pos_inc >= POS_W'(CMD_MAX + 1)) begin
                        n_phase         = PH_IDLE;
                        n_out.event_res = EV_LONGCMD;
                    end
                end
            end
            PH_ARG: begin
                if (b == CH_STAR) begin
                    n_arg_len = r_pos[6:0];
                    n_rx_sum  = '0;
                    n_pos     = '0;
                    n_phase   = PH_CHK;
                end else begin
                    n_xor = r_xor ^ b;
                    n_pos = w_pos_inc;
                    if (w_pos_inc >= POS_W'(ARG_MAX + 1)) begin
                        n_phase         = PH_IDLE;
                        n_out.event_res = EV_LONGARG;
                    end
                end
            end
            PH_CHK: begin
                if (b == CH_CR) begin
                    if (r_xor == r_rx_sum) begin
                        n_phase = PH_CR;
                    end else begin
                        n_phase                 = PH_IDLE;
                        n_out.event_res         = EV_BADSUM;
                        n_out.computed_checksum = r_xor;
                    end
                end else begin
                    n_rx_sum = {r_rx_sum[3:0], 4'h0} + hex_value(b);
                    n_pos    = w_pos_inc;
                    if (w_pos_inc >= POS_W'(CHK_MAX)) begin
                        n_phase         = PH_IDLE;
                        n_out.event_res = EV_LONGSUM;
                    end
                end
            end
            PH_CR: begin
                n_phase = PH_IDLE;
                if (b == CH_LF) begin
                    n_out.event_res         = EV_OK;
                    n_out.sentence_kind     = classify(r_cmd);
                    n_out.command_length    = r_cmd_len;
                    n_out.argument_length   = r_arg_len;
                    n_out.computed_checksum = r_xor;
                end else begin
                    n_out.event_res = EV_NOLF;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (b == CH_DOLLAR) begin
                    n_pos   = '0;
                    n_xor   = '0;
                    n_phase = PH_CMD;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_pos       <= '0;
            r_xor       <= '0;
            r_rx_sum    <= '0;
            r_cmd       <= '0;
            r_cmd_len   <= '0;
            r_arg_len   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_phase     <= n_phase;
                r_pos       <= n_pos;
                r_xor       <= n_xor;
                r_rx_sum    <= n_rx_sum;
                r_cmd       <= n_cmd;
                r_cmd_len   <= n_cmd_len;
                r_arg_len   <= n_arg_len;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // status payload, loaded with each accepted character
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= n_out;
        end
    end

endmodule
